@@ rtl/gdr_pkg.sv @@
// ----------------------------------------------------------------------------
// gdr_pkg
// Shared constants, codes and types of the grid depth-first route marker.
// ----------------------------------------------------------------------------
`default_nettype none
package gdr_pkg;
  localparam int MAX_ROWS  = 64;
  localparam int MAX_COLS  = 64;
  localparam int CELLS     = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W    = $clog2(CELLS);
  localparam int DEPTH_W   = $clog2(CELLS + 1);
  localparam int POS_W     = 6;
  localparam int DIM_W     = 7;
  localparam int CHAR_W    = 8;
  localparam int FRAME_W   = 2 * POS_W + 4;

  localparam logic [CHAR_W-1:0] CH_OPEN  = 8'h45; // E
  localparam logic [CHAR_W-1:0] CH_GOAL  = 8'h47; // G
  localparam logic [CHAR_W-1:0] CH_HELD  = 8'h67; // g
  localparam logic [CHAR_W-1:0] CH_VISIT = 8'h56; // V
  localparam logic [CHAR_W-1:0] CH_ROUTE = 8'h52; // R
  localparam logic [DIM_W-1:0]  TALLY_MAX = 7'd127;

  localparam logic [1:0] KIND_LOAD  = 2'd0;
  localparam logic [1:0] KIND_START = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  localparam logic [1:0] REG_ROWS   = 2'd0;
  localparam logic [1:0] REG_COLS   = 2'd1;
  localparam logic [1:0] REG_TARGET = 2'd2;

  typedef struct packed {
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic [1:0]       dir;
    logic [1:0]       tries;
  } frame_t;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_RD    = 9'b000000010,
    S_ST0   = 9'b000000100,
    S_TRY   = 9'b000001000,
    S_CHK   = 9'b000010000,
    S_MARK  = 9'b000100000,
    S_MARKW = 9'b001000000,
    S_POP   = 9'b010000000,
    S_POPW  = 9'b100000000
  } state_t;

  function automatic logic [ADDR_W-1:0] cell_idx(input logic [POS_W-1:0] r,
                                                 input logic [POS_W-1:0] c);
    cell_idx = ADDR_W'(ADDR_W'(r) * ADDR_W'(MAX_COLS) + ADDR_W'(c));
  endfunction
endpackage
`default_nettype wire

@@ rtl/grid_dfs_goal_route_marker.sv @@
// ----------------------------------------------------------------------------
// grid_dfs_goal_route_marker
// Grid loader and depth-first goal walker over visit, route and stack RAMs.
// ----------------------------------------------------------------------------
// channel   signals                                     beat
// command   start, busy, kind, cell_row/col, cell_char  start & !busy
// result    done, found, goals_reached, visit/route     done, one cycle
// config    cfg_we, cfg_index, cfg_data                 cfg_we
//
// Load and kind 3 answer with a result strobed on the next cycle.
// Read captures the registered RAM read data in S_RD with the result strobe.
// Start runs the walk by steps of the stack sequencer (a pop is longest), set by
// the single read port of each map RAM; busy stays high until the result strobe.
// Synchronous reset clears control state; the RAMs are not cleared.
// The receiver cannot stall: each result shows for one cycle.
`default_nettype none
module grid_dfs_goal_route_marker (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [1:0]                   kind,
  input  wire logic [gdr_pkg::POS_W-1:0]    cell_row,
  input  wire logic [gdr_pkg::POS_W-1:0]    cell_col,
  input  wire logic [gdr_pkg::CHAR_W-1:0]   cell_char,
  input  wire logic                         cfg_we,
  input  wire logic [1:0]                   cfg_index,
  input  wire logic [gdr_pkg::DIM_W-1:0]    cfg_data,
  output logic                              done,
  output logic                              found,
  output logic [gdr_pkg::DIM_W-1:0]         goals_reached,
  output logic [gdr_pkg::CHAR_W-1:0]        visit_char,
  output logic [gdr_pkg::CHAR_W-1:0]        route_char
);
  localparam int AW = gdr_pkg::ADDR_W;
  localparam int DWID = gdr_pkg::DEPTH_W;
  localparam int PW = gdr_pkg::POS_W;
  localparam int NW = gdr_pkg::DIM_W;
  localparam int CW = gdr_pkg::CHAR_W;

  gdr_pkg::state_t state, state_next;
  logic [NW-1:0] grid_rows, grid_cols, goal_target;
  logic [NW-1:0] rows_c, cols_c;
  gdr_pkg::frame_t top;
  logic [PW-1:0] nb_r, nb_c;
  logic [1:0] nb_d;
  logic [DWID-1:0] depth;
  logic [NW-1:0] tally;
  logic on_route, success, rd_in;

  logic vis_we, rte_we, stk_we;
  logic [AW-1:0] vis_wa, rte_wa, vis_ra, rte_ra, stk_wa, stk_ra;
  logic [CW-1:0] vis_wd, rte_wd, vis_rd, rte_rd;
  gdr_pkg::frame_t stk_rd;

  logic accept, in_cell;
  logic [AW-1:0] port_idx, idx, nidx;
  logic [1:0] turn, d;
  logic step_ok;
  logic [PW-1:0] nr, nc;
  logic [NW-1:0] tally_inc;
  logic v_ok, v_goal;

  assign busy = (state != gdr_pkg::S_IDLE);
  assign accept = start && !busy;
  assign in_cell = ({1'b0, cell_row} < (PW+1)'(gdr_pkg::MAX_ROWS)) &&
                   ({1'b0, cell_col} < (PW+1)'(gdr_pkg::MAX_COLS));
  assign port_idx = gdr_pkg::cell_idx(cell_row, cell_col);
  assign idx = gdr_pkg::cell_idx(top.row, top.col);
  assign nidx = gdr_pkg::cell_idx(nb_r, nb_c);
  assign found = success;
  assign goals_reached = tally;

  assign rows_c = (grid_rows == '0) ? NW'(1) :
                  (grid_rows > NW'(gdr_pkg::MAX_ROWS)) ? NW'(gdr_pkg::MAX_ROWS) : grid_rows;
  assign cols_c = (grid_cols == '0) ? NW'(1) :
                  (grid_cols > NW'(gdr_pkg::MAX_COLS)) ? NW'(gdr_pkg::MAX_COLS) : grid_cols;

  always_comb begin
    case (top.tries)
      2'd0:    turn = 2'd0;
      2'd1:    turn = 2'd1;
      default: turn = 2'd3;
    endcase
    d = top.dir + turn;
    nr = top.row;
    nc = top.col;
    step_ok = 1'b0;
    case (d)
      2'd0: begin
        nc = top.col + PW'(1);
        step_ok = ({1'b0, top.col} + NW'(1)) < cols_c;
      end
      2'd1: begin
        nr = top.row + PW'(1);
        step_ok = ({1'b0, top.row} + NW'(1)) < rows_c;
      end
      2'd2: begin
        nc = top.col - PW'(1);
        step_ok = (top.col != '0);
      end
      default: begin
        nr = top.row - PW'(1);
        step_ok = (top.row != '0);
      end
    endcase
    step_ok = step_ok && !success;
  end

  assign tally_inc = (tally < gdr_pkg::TALLY_MAX) ? tally + NW'(1) : tally;
  assign v_goal = (vis_rd == gdr_pkg::CH_GOAL);
  assign v_ok = v_goal || (vis_rd == gdr_pkg::CH_OPEN);

  // RAM port steering and next-state logic
  always_comb begin
    vis_we = 1'b0; vis_wa = idx; vis_wd = gdr_pkg::CH_VISIT; vis_ra = idx;
    rte_we = 1'b0; rte_wa = idx; rte_wd = gdr_pkg::CH_ROUTE; rte_ra = idx;
    stk_we = 1'b0; stk_wa = AW'(depth - DWID'(1)); stk_ra = AW'(depth - DWID'(2));
    state_next = state;
    case (state)
      gdr_pkg::S_IDLE: begin
        vis_ra = (kind == gdr_pkg::KIND_START) ? '0 : port_idx;
        rte_ra = port_idx;
        if (accept) begin
          if (kind == gdr_pkg::KIND_LOAD && in_cell) begin
            vis_we = 1'b1; vis_wa = port_idx; vis_wd = cell_char;
            rte_we = 1'b1; rte_wa = port_idx; rte_wd = cell_char;
          end
          if (kind == gdr_pkg::KIND_READ) state_next = gdr_pkg::S_RD;
          if (kind == gdr_pkg::KIND_START) state_next = gdr_pkg::S_ST0;
        end
      end
      gdr_pkg::S_RD: state_next = gdr_pkg::S_IDLE;
      gdr_pkg::S_ST0: begin
        vis_we = 1'b1; vis_wa = '0;
        vis_wd = v_goal ? gdr_pkg::CH_HELD : gdr_pkg::CH_VISIT;
        state_next = gdr_pkg::S_TRY;
      end
      gdr_pkg::S_TRY: begin
        if (top.tries == 2'd3) begin
          state_next = gdr_pkg::S_POP;
        end else if (step_ok) begin
          vis_ra = gdr_pkg::cell_idx(nr, nc);
          state_next = gdr_pkg::S_CHK;
        end else begin
          state_next = gdr_pkg::S_MARKW;
        end
      end
      gdr_pkg::S_CHK: begin
        rte_ra = nidx;
        if (!v_ok) begin
          state_next = gdr_pkg::S_MARK;
        end else begin
          rte_we = v_goal;
          if (v_goal && tally_inc == goal_target) begin
            state_next = gdr_pkg::S_TRY;
          end else if (depth < DWID'(gdr_pkg::CELLS)) begin
            vis_we = 1'b1; vis_wa = nidx;
            vis_wd = v_goal ? gdr_pkg::CH_HELD : gdr_pkg::CH_VISIT;
            stk_we = 1'b1;
            state_next = gdr_pkg::S_MARKW;
          end else begin
            state_next = gdr_pkg::S_MARK;
          end
        end
      end
      gdr_pkg::S_MARK: state_next = gdr_pkg::S_MARKW;
      gdr_pkg::S_MARKW: begin
        rte_we = on_route && (rte_rd != gdr_pkg::CH_GOAL);
        state_next = gdr_pkg::S_TRY;
      end
      gdr_pkg::S_POP: begin
        vis_we = (vis_rd == gdr_pkg::CH_HELD); vis_wd = gdr_pkg::CH_GOAL;
        state_next = (depth == DWID'(1)) ? gdr_pkg::S_IDLE : gdr_pkg::S_POPW;
      end
      gdr_pkg::S_POPW: state_next = gdr_pkg::S_MARK;
      default: state_next = gdr_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gdr_pkg::S_IDLE;
      grid_rows <= NW'(1);
      grid_cols <= NW'(1);
      goal_target <= NW'(1);
      depth <= '0;
      tally <= '0;
      on_route <= 1'b0;
      success <= 1'b0;
      done <= 1'b0;
    end else begin
      state <= state_next;
      done <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          gdr_pkg::REG_ROWS:   grid_rows <= cfg_data;
          gdr_pkg::REG_COLS:   grid_cols <= cfg_data;
          gdr_pkg::REG_TARGET: goal_target <= cfg_data;
          default: ;
        endcase
      end
      case (state)
        gdr_pkg::S_IDLE: begin
          if (accept) begin
            if (kind == gdr_pkg::KIND_START) begin
              depth <= DWID'(1);
              tally <= '0;
              on_route <= 1'b0;
              success <= 1'b0;
            end else if (kind != gdr_pkg::KIND_READ) begin
              done <= 1'b1;
            end
          end
        end
        gdr_pkg::S_RD: done <= 1'b1;
        gdr_pkg::S_CHK: begin
          if (v_ok) begin
            on_route <= v_goal;
            if (v_goal) tally <= tally_inc;
            if (v_goal && tally_inc == goal_target) begin
              success <= 1'b1;
            end else if (depth < DWID'(gdr_pkg::CELLS)) begin
              depth <= depth + DWID'(1);
            end
          end
        end
        gdr_pkg::S_POP: begin
          if (rte_rd == gdr_pkg::CH_ROUTE) on_route <= 1'b1;
          depth <= depth - DWID'(1);
          if (depth == DWID'(1)) done <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // payload and walk frame registers
  always_ff @(posedge clk) begin
    case (state)
      gdr_pkg::S_IDLE: begin
        if (accept) begin
          rd_in <= in_cell;
          visit_char <= '0;
          route_char <= '0;
        end
      end
      gdr_pkg::S_RD: begin
        visit_char <= rd_in ? vis_rd : '0;
        route_char <= rd_in ? rte_rd : '0;
      end
      gdr_pkg::S_ST0: top <= '{row: '0, col: '0, dir: 2'd0, tries: 2'd0};
      gdr_pkg::S_TRY: begin
        if (top.tries != 2'd3) begin
          top.tries <= top.tries + 2'd1;
          nb_r <= nr;
          nb_c <= nc;
          nb_d <= d;
        end
      end
      gdr_pkg::S_CHK: begin
        if (v_ok && !(v_goal && tally_inc == goal_target) &&
            depth < DWID'(gdr_pkg::CELLS)) begin
          top <= '{row: nb_r, col: nb_c, dir: nb_d, tries: 2'd0};
        end
      end
      gdr_pkg::S_POPW: top <= stk_rd;
      default: ;
    endcase
  end

  gdr_ram #(.AW(AW), .DW(CW)) u_visit (
    .clk(clk), .we(vis_we), .waddr(vis_wa), .wdata(vis_wd),
    .raddr(vis_ra), .rdata(vis_rd)
  );

  gdr_ram #(.AW(AW), .DW(CW)) u_route (
    .clk(clk), .we(rte_we), .waddr(rte_wa), .wdata(rte_wd),
    .raddr(rte_ra), .rdata(rte_rd)
  );

  gdr_ram #(.AW(AW), .DW(gdr_pkg::FRAME_W)) u_stack (
    .clk(clk), .we(stk_we), .waddr(stk_wa), .wdata(top),
    .raddr(stk_ra), .rdata(stk_rd)
  );
endmodule
`default_nettype wire

@@ rtl/gdr_ram.sv @@
// ----------------------------------------------------------------------------
// gdr_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none
module gdr_ram #(
  parameter int AW = 12,
  parameter int DW = 8
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);
  logic [DW-1:0] mem [0:(1<<AW)-1];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ rtl/gdr_checker.sv @@
// ----------------------------------------------------------------------------
// gdr_checker
// Port-level timing checks of the route marker, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module gdr_checker (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       start,
  input wire logic                       busy,
  input wire logic [1:0]                 kind,
  input wire logic                       done
);
  a_load_beat: assert property (@(posedge clk) disable iff (rst)
    start && !busy && kind == gdr_pkg::KIND_LOAD |=> done && !busy)
    else $error("load beat not answered next cycle");

  a_read_beat: assert property (@(posedge clk) disable iff (rst)
    start && !busy && kind == gdr_pkg::KIND_READ |=> busy && !done ##1 done)
    else $error("read beat not answered after RAM latency");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && kind == gdr_pkg::KIND_START |=> busy && !done)
    else $error("walk did not hold busy");

  a_reset: assert property (@(posedge clk)
    rst |=> !busy && !done)
    else $error("control state not cleared by reset");
endmodule

bind grid_dfs_goal_route_marker gdr_checker u_chk (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .kind(kind), .done(done)
);
`default_nettype wire

@@ test/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the grid depth-first goal route marker. Loads small
// random grids plus a few extreme shapes, runs walks under several register
// settings and reads the visit and route maps back. Every result beat is
// compared field by field with a directed want or a map-walking predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb;
  import gdr_pkg::*;

  localparam logic [1:0] KIND_NOP = 2'd3;

  typedef struct packed {
    logic       fnd;
    logic [6:0] goals;
    logic [7:0] vch;
    logic [7:0] rch;
  } beat_t;

  typedef struct {
    logic [1:0] kind;
    int         row;
    int         col;
    logic [7:0] ch;
    bit         typed;
    beat_t      want;
  } stim_t;

  logic clk, rst, start, busy, cfg_we, done, found;
  logic [1:0] kind, cfg_index;
  logic [POS_W-1:0] cell_row, cell_col;
  logic [CHAR_W-1:0] cell_char, visit_char, route_char;
  logic [DIM_W-1:0] cfg_data, goals_reached;

  grid_dfs_goal_route_marker uut (.*);

  logic [7:0] visit_img [CELLS];
  logic [7:0] route_img [CELLS];
  int stk_r [CELLS], stk_c [CELLS], stk_d [CELLS], stk_t [CELLS];
  int depth, tally, rows_reg, cols_reg, target_reg;
  bit on_route, success;
  beat_t pending_q [$];
  int errors, items;
  bit no_gaps;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("grid_dfs_goal_route_marker: mismatch");
    $finish;
  end

  task automatic report(string what, int got, int want);
    errors++;
    $display("error at %0t: %s got %0h want %0h", $realtime, what, got, want);
  endtask

  always @(posedge clk) begin
    beat_t w;
    if (!rst && done) begin
      if (pending_q.size() == 0) begin
        report("unexpected beat", 1, 0);
      end else begin
        w = pending_q.pop_front();
        if (found !== w.fnd) report("found", found, w.fnd);
        if (goals_reached !== w.goals) report("goals_reached", goals_reached, w.goals);
        if (visit_char !== w.vch) report("visit_char", visit_char, w.vch);
        if (route_char !== w.rch) report("route_char", route_char, w.rch);
      end
    end
  end

  function automatic int clamp_dim(int v);
    if (v == 0) return 1;
    return v > 64 ? 64 : v;
  endfunction

  function automatic void mark(int idx);
    if (on_route && route_img[idx] != CH_GOAL) route_img[idx] = CH_ROUTE;
  endfunction

  function automatic void push_cell(int r, int c, int d);
    int idx;
    idx = r * MAX_COLS + c;
    mark(idx);
    visit_img[idx] = (visit_img[idx] == CH_GOAL) ? CH_HELD : CH_VISIT;
    stk_r[depth] = r;
    stk_c[depth] = c;
    stk_d[depth] = d;
    stk_t[depth] = 0;
    depth++;
  endfunction

  function automatic void walk_grid();
    int rows, cols, t, r, c, idx, d, nr, nc, nidx;
    logic [7:0] v;
    rows = clamp_dim(rows_reg);
    cols = clamp_dim(cols_reg);
    depth = 0;
    tally = 0;
    on_route = 0;
    success = 0;
    push_cell(0, 0, 0);
    while (depth > 0) begin
      t = depth - 1;
      r = stk_r[t];
      c = stk_c[t];
      idx = r * MAX_COLS + c;
      if (stk_t[t] < 3) begin
        d = (stk_d[t] + (stk_t[t] == 2 ? 3 : stk_t[t])) & 3;
        nr = r + (d == 1 ? 1 : d == 3 ? -1 : 0);
        nc = c + (d == 0 ? 1 : d == 2 ? -1 : 0);
        stk_t[t]++;
        if (!success && nr >= 0 && nc >= 0 && nr < rows && nc < cols) begin
          nidx = nr * MAX_COLS + nc;
          v = visit_img[nidx];
          if (v == CH_OPEN || v == CH_GOAL) begin
            on_route = 0;
            if (v == CH_GOAL) begin
              if (tally < 127) tally++;
              on_route = 1;
              route_img[idx] = CH_ROUTE;
              if (tally == target_reg) begin
                success = 1;
                mark(idx);
                continue;
              end
            end
            push_cell(nr, nc, d);
            continue;
          end
        end
        mark(idx);
      end else begin
        if (visit_img[idx] == CH_HELD) visit_img[idx] = CH_GOAL;
        if (route_img[idx] == CH_ROUTE) on_route = 1;
        depth--;
        if (depth > 0) mark(stk_r[depth-1] * MAX_COLS + stk_c[depth-1]);
      end
    end
  endfunction

  function automatic beat_t predict_beat(logic [1:0] k, int r, int c, logic [7:0] ch);
    beat_t b;
    int idx;
    idx = r * MAX_COLS + c;
    b = '0;
    if (k == KIND_LOAD) begin
      visit_img[idx] = ch;
      route_img[idx] = ch;
    end else if (k == KIND_START) begin
      walk_grid();
    end else if (k == KIND_READ) begin
      b.vch = visit_img[idx];
      b.rch = route_img[idx];
    end
    b.fnd = success;
    b.goals = 7'(tally);
    return b;
  endfunction

  task automatic send(logic [1:0] k, int r, int c, logic [7:0] ch,
                      bit typed = 0, beat_t want = '0);
    beat_t b;
    repeat (no_gaps ? 0 : $urandom_range(0, 10)) begin
      start = 0;
      @(negedge clk);
    end
    start = 1;
    kind = k;
    cell_row = 6'(r);
    cell_col = 6'(c);
    cell_char = ch;
    do @(posedge clk); while (busy);
    b = predict_beat(k, r, c, ch);
    pending_q.push_back(typed ? want : b);
    items++;
    @(negedge clk);
    start = 0;
  endtask

  task automatic write_reg(logic [1:0] idx, int val);
    wait (pending_q.size() == 0);
    repeat (4) @(negedge clk);
    cfg_we = 1;
    cfg_index = idx;
    cfg_data = 7'(val);
    @(negedge clk);
    cfg_we = 0;
    if (idx == REG_ROWS) rows_reg = val;
    else if (idx == REG_COLS) cols_reg = val;
    else target_reg = val;
  endtask

  function automatic logic [7:0] grid_char();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return CH_OPEN;
    if (p < 72) return CH_GOAL;
    if (p < 90) return 8'h4F;
    return 8'($urandom());
  endfunction

  stim_t directed [$];

  function automatic void row_of(logic [1:0] k, int r, int c, logic [7:0] ch,
                                 logic [7:0] v, logic [7:0] rc);
    stim_t s;
    s.kind = k;
    s.row = r;
    s.col = c;
    s.ch = ch;
    s.typed = 1;
    s.want = '{fnd: 0, goals: 0, vch: v, rch: rc};
    directed.push_back(s);
  endfunction

  initial begin
    int rv, cv, tv, er, ec, n, p;
    rst = 1;
    start = 0;
    kind = KIND_LOAD;
    cell_row = 0;
    cell_col = 0;
    cell_char = 0;
    cfg_we = 0;
    cfg_index = REG_ROWS;
    cfg_data = 0;
    rows_reg = 1;
    cols_reg = 1;
    target_reg = 1;
    depth = 0;
    tally = 0;
    on_route = 0;
    success = 0;
    errors = 0;
    items = 0;
    no_gaps = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 0;

    row_of(KIND_NOP,   0,  0, 8'h00,   8'h00,   8'h00);
    row_of(KIND_LOAD,  0,  0, CH_OPEN, 8'h00,   8'h00);
    row_of(KIND_READ,  0,  0, 8'h00,   CH_OPEN, CH_OPEN);
    row_of(KIND_START, 0,  0, 8'h00,   8'h00,   8'h00);
    row_of(KIND_READ,  0,  0, 8'h00,   CH_VISIT, CH_OPEN);
    row_of(KIND_LOAD, 63, 63, 8'hFF,   8'h00,   8'h00);
    row_of(KIND_READ, 63, 63, 8'h00,   8'hFF,   8'hFF);
    row_of(KIND_LOAD,  0, 63, 8'h00,   8'h00,   8'h00);
    row_of(KIND_READ,  0, 63, 8'hFF,   8'h00,   8'h00);
    row_of(KIND_LOAD, 63,  0, 8'h4F,   8'h00,   8'h00);
    row_of(KIND_READ, 63,  0, 8'h00,   8'h4F,   8'h4F);
    row_of(KIND_LOAD,  0,  0, CH_GOAL, 8'h00,   8'h00);
    row_of(KIND_START, 0,  0, 8'h00,   8'h00,   8'h00);
    row_of(KIND_READ,  0,  0, 8'h00,   CH_GOAL, CH_GOAL);
    row_of(KIND_NOP,  63, 63, 8'hFF,   8'h00,   8'h00);
    foreach (directed[i])
      send(directed[i].kind, directed[i].row, directed[i].col, directed[i].ch,
           directed[i].typed, directed[i].want);

    for (int ph = 0; items < 450; ph++) begin
      p = $urandom_range(0, 99);
      if (ph == 0) begin rv = 64; cv = 1; end
      else if (ph == 1) begin rv = 1; cv = 127; end
      else if (ph == 2) begin rv = 0; cv = 0; end
      else if (p < 6) begin rv = $urandom_range(64, 127); cv = $urandom_range(0, 2); end
      else if (p < 12) begin rv = $urandom_range(0, 2); cv = $urandom_range(64, 127); end
      else begin rv = $urandom_range(1, 6); cv = $urandom_range(1, 6); end
      p = $urandom_range(0, 99);
      if (ph == 3 || p < 6) tv = 0;
      else if (ph == 4 || p < 10) tv = 127;
      else if (p < 13) tv = 100;
      else tv = $urandom_range(1, 4);
      write_reg(REG_ROWS, rv);
      write_reg(REG_COLS, cv);
      write_reg(REG_TARGET, tv);
      er = clamp_dim(rv);
      ec = clamp_dim(cv);
      no_gaps = ($urandom_range(0, 3) == 0);
      for (int r = 0; r < er; r++)
        for (int c = 0; c < ec; c++) send(KIND_LOAD, r, c, grid_char());
      send(KIND_START, 0, 0, 8'($urandom()));
      n = $urandom_range(3, 8);
      repeat (n) send(KIND_READ, $urandom_range(0, er-1), $urandom_range(0, ec-1),
                      8'($urandom()));
      if ($urandom_range(0, 2) == 0) begin
        repeat ($urandom_range(0, 3))
          send(KIND_LOAD, $urandom_range(0, er-1), $urandom_range(0, ec-1), grid_char());
        send(KIND_START, $urandom_range(0, 63), $urandom_range(0, 63), 8'($urandom()));
        repeat ($urandom_range(2, 5))
          send(KIND_READ, $urandom_range(0, er-1), $urandom_range(0, ec-1), 8'h00);
      end
      if ($urandom_range(0, 4) == 0)
        send(KIND_NOP, $urandom_range(0, 63), $urandom_range(0, 63), 8'($urandom()));
    end

    wait (pending_q.size() == 0);
    repeat (20) @(posedge clk);
    if (errors == 0) $display("grid_dfs_goal_route_marker: match");
    else $display("grid_dfs_goal_route_marker: mismatch");
    $finish;
  end
endmodule

@@ grid_dfs_goal_route_marker.f @@
rtl/gdr_pkg.sv
rtl/gdr_ram.sv
rtl/grid_dfs_goal_route_marker.sv
rtl/gdr_checker.sv
test/tb.sv
